FILE: design/rmv_pkg.sv
// Shared constants and types of the running mean, variance and extremes block.
`default_nettype none

package rmv_pkg;

   // Field widths.
   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 20;
   localparam int FRAC_BITS   = 16;
   localparam int MEAN_BITS   = SAMPLE_BITS + FRAC_BITS;
   localparam int DIFF_BITS   = MEAN_BITS + 1;
   localparam int MAG_BITS    = MEAN_BITS;
   localparam int PROD_BITS   = 2 * MAG_BITS;
   localparam int M2_SHIFT    = 24;
   localparam int M2_BITS     = 61;
   localparam int PART_BITS   = PROD_BITS - M2_SHIFT;
   localparam int STEP_BITS   = $clog2(MAG_BITS);

   // Limits and clear values.
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [M2_BITS-1:0]    M2_MAX    = '1;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [STEP_BITS-1:0]  STEP_LAST = STEP_BITS'(MAG_BITS - 1);

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_MUL,
      ST_PUBLISH
   } rmv_state_type;

endpackage

`default_nettype wire

FILE: design/rmv_if.sv
// Valid/ready channels that carry sample words in and statistics words out.
`default_nettype none

interface rmv_req_if
   import rmv_pkg::*;
   ;
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          restart;

   modport source (output valid, output sample, output restart, input ready);
   modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface rmv_rsp_if
   import rmv_pkg::*;
   ;
   logic                          valid;
   logic                          ready;
   logic [COUNT_BITS-1:0]         count_out;
   logic signed [SAMPLE_BITS-1:0] min_out;
   logic signed [SAMPLE_BITS-1:0] max_out;
   logic signed [MEAN_BITS-1:0]   mean_out;
   logic [M2_BITS-1:0]            m2_out;
   logic                          saturated;

   modport source (output valid, output count_out, output min_out, output max_out,
                   output mean_out, output m2_out, output saturated, input ready);
   modport sink   (input valid, input count_out, input min_out, input max_out,
                   input mean_out, input m2_out, input saturated, output ready);
endinterface

`default_nettype wire

FILE: design/running_mean_variance_minmax.sv
// Top level of the running mean, variance and extremes block.
//
// Each accepted word adds one signed 16-bit sample to the running statistics and
// returns one word with the sample count, minimum, maximum, mean (signed Q15.16,
// quotient truncated toward zero) and the sum of squared deviations (Q.8,
// truncated), with a sticky flag for count or deviation-sum saturation; a set
// restart bit clears everything before the sample is added. A sample is worked
// on alone: the input is closed from acceptance until its result is loaded. The
// bit-serial divider produces one of the 32 quotient bits of the mean step per
// cycle, then the bit-serial multiplier takes one of the 32 multiplier bits of
// the deviation product per cycle; the first sample after a clear or reset
// skips both. The result sits in an output register, so the next sample is
// taken while a result still waits.
`default_nettype none

module running_mean_variance_minmax
   import rmv_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   rmv_req_if.sink    req_ch,
   rmv_rsp_if.source  rsp_ch
);

   rmv_state_type state_ff, state_in;

   // Accepted sample.
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic                          restart_ff;

   // Statistics.
   logic [COUNT_BITS-1:0]         count_ff;
   logic signed [SAMPLE_BITS-1:0] min_ff;
   logic signed [SAMPLE_BITS-1:0] max_ff;
   logic signed [MEAN_BITS-1:0]   mean_ff;
   logic [M2_BITS-1:0]            m2_ff;
   logic                          sticky_ff;

   // Deviation of the sample from the old mean, as sign and magnitude.
   logic [MAG_BITS-1:0]           d_mag_ff;
   logic                          d_neg_ff;

   // Output register.
   logic                          rsp_valid_ff;
   logic [COUNT_BITS-1:0]         rsp_count_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_min_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_max_ff;
   logic signed [MEAN_BITS-1:0]   rsp_mean_ff;
   logic [M2_BITS-1:0]            rsp_m2_ff;
   logic                          rsp_sat_ff;

   // Sequencer outputs and unit handshakes.
   logic                          accept;
   logic                          out_load;
   logic                          rsp_take;
   logic                          div_start;
   logic                          div_done;
   logic                          mul_start;
   logic                          mul_done;

   // Datapath values.
   logic [COUNT_BITS-1:0]         count_eff;
   logic signed [SAMPLE_BITS-1:0] min_eff;
   logic signed [SAMPLE_BITS-1:0] max_eff;
   logic [M2_BITS-1:0]            m2_eff;
   logic                          sticky_eff;
   logic                          count_full;
   logic [COUNT_BITS-1:0]         count_new;
   logic                          first_sample;
   logic signed [MEAN_BITS-1:0]   xq;
   logic signed [DIFF_BITS-1:0]   d_full;
   logic [DIFF_BITS-1:0]          d_abs;
   logic [MAG_BITS-1:0]           quotient;
   logic signed [DIFF_BITS-1:0]   q_signed;
   logic signed [DIFF_BITS-1:0]   mean_new_full;
   logic signed [DIFF_BITS-1:0]   d2_full;
   logic [DIFF_BITS-1:0]          d2_abs;
   logic [MAG_BITS-1:0]           d2_mag;
   logic [PROD_BITS-1:0]          product;
   logic [PART_BITS-1:0]          part;
   logic [M2_BITS:0]              m2_sum;

   // Bit-serial arithmetic units.
   rmv_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (d_abs[MAG_BITS-1:0]),
      .divisor  (count_new),
      .done     (div_done),
      .quotient (quotient)
   );

   rmv_multiplier u_multiplier (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (d_mag_ff),
      .op_b    (d2_mag),
      .done    (mul_done),
      .product (product)
   );

   // Statistics as seen after an optional restart, then the new count and the
   // first deviation of the new sample.
   always_comb begin
      count_eff    = restart_ff ? '0 : count_ff;
      min_eff      = restart_ff ? SAMPLE_MAX : min_ff;
      max_eff      = restart_ff ? SAMPLE_MIN : max_ff;
      m2_eff       = restart_ff ? '0 : m2_ff;
      sticky_eff   = restart_ff ? 1'b0 : sticky_ff;
      count_full   = (count_eff == COUNT_MAX);
      count_new    = count_full ? count_eff : count_eff + 1'b1;
      first_sample = (count_new == COUNT_ONE);
      xq           = {x_ff, {FRAC_BITS{1'b0}}};
      d_full       = {xq[MEAN_BITS-1], xq} - {mean_ff[MEAN_BITS-1], mean_ff};
      d_abs        = d_full[DIFF_BITS-1] ? -d_full : d_full;
   end

   // Mean step with the truncated quotient, and the deviation from the new mean.
   always_comb begin
      q_signed      = d_neg_ff ? -{1'b0, quotient} : {1'b0, quotient};
      mean_new_full = {mean_ff[MEAN_BITS-1], mean_ff} + q_signed;
      d2_full       = {xq[MEAN_BITS-1], xq} - mean_new_full;
      d2_abs        = d2_full[DIFF_BITS-1] ? -d2_full : d2_full;
      d2_mag        = d2_abs[MAG_BITS-1:0];
   end

   // Deviation-sum accumulation in Q.8; a carry out of the top bit saturates.
   always_comb begin
      part   = product[PROD_BITS-1:M2_SHIFT];
      m2_sum = {1'b0, m2_ff} + {{(M2_BITS+1-PART_BITS){1'b0}}, part};
   end

   // Sequencer: next state and unit start pulses.
   always_comb begin
      state_in  = state_ff;
      accept    = 1'b0;
      out_load  = 1'b0;
      div_start = 1'b0;
      mul_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            accept = req_ch.valid;
            if (req_ch.valid) state_in = ST_PREP;
         end
         ST_PREP: begin
            if (first_sample) begin
               state_in = ST_PUBLISH;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               mul_start = 1'b1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) state_in = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Accepted sample word.
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff       <= req_ch.sample;
         restart_ff <= req_ch.restart;
      end
   end

   // Statistics update, one part per sequencer step.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         min_ff    <= SAMPLE_MAX;
         max_ff    <= SAMPLE_MIN;
         mean_ff   <= '0;
         m2_ff     <= '0;
         sticky_ff <= 1'b0;
      end else begin
         if (state_ff == ST_PREP) begin
            count_ff  <= count_new;
            min_ff    <= (x_ff < min_eff) ? x_ff : min_eff;
            max_ff    <= (x_ff > max_eff) ? x_ff : max_eff;
            sticky_ff <= sticky_eff | count_full;
            if (first_sample) begin
               mean_ff <= xq;
               m2_ff   <= '0;
            end else begin
               m2_ff   <= m2_eff;
            end
         end
         if (state_ff == ST_DIV && div_done) begin
            mean_ff <= mean_new_full[MEAN_BITS-1:0];
         end
         if (state_ff == ST_MUL && mul_done) begin
            if (m2_sum[M2_BITS]) begin
               m2_ff     <= M2_MAX;
               sticky_ff <= 1'b1;
            end else begin
               m2_ff <= m2_sum[M2_BITS-1:0];
            end
         end
      end
   end

   // Deviation from the old mean, kept for the product.
   always_ff @(posedge clock) begin
      if (state_ff == ST_PREP) begin
         d_mag_ff <= d_abs[MAG_BITS-1:0];
         d_neg_ff <= d_full[DIFF_BITS-1];
      end
   end

   // Output register: valid drops when the word is taken and no new one loads.
   assign rsp_take = rsp_valid_ff && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_count_ff <= count_ff;
         rsp_min_ff   <= min_ff;
         rsp_max_ff   <= max_ff;
         rsp_mean_ff  <= mean_ff;
         rsp_m2_ff    <= m2_ff;
         rsp_sat_ff   <= sticky_ff;
      end
   end

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.count_out = rsp_count_ff;
   assign rsp_ch.min_out   = rsp_min_ff;
   assign rsp_ch.max_out   = rsp_max_ff;
   assign rsp_ch.mean_out  = rsp_mean_ff;
   assign rsp_ch.m2_out    = rsp_m2_ff;
   assign rsp_ch.saturated = rsp_sat_ff;

endmodule

`default_nettype wire

FILE: design/rmv_divider.sv
// Restoring divider of a magnitude by the sample count, one quotient bit per cycle.
`default_nettype none

module rmv_divider
   import rmv_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [MAG_BITS-1:0]   dividend,
   input  wire logic [COUNT_BITS-1:0] divisor,
   output logic                       done,
   output logic [MAG_BITS-1:0]        quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [MAG_BITS-1:0]   num_ff, num_in;
   logic [COUNT_BITS-1:0] den_ff, den_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS:0]   rem_shift;
   logic [COUNT_BITS:0]   trial;
   logic                  fits;

   // One step: bring down the next dividend bit and try to subtract the divisor.
   // The remainder stays below the divisor, so the shifted value is below twice it.
   always_comb begin
      rem_shift = {rem_ff, num_ff[MAG_BITS-1]};
      trial     = rem_shift - {1'b0, den_ff};
      fits      = ~trial[COUNT_BITS];
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      if (busy_ff) begin
         rem_in  = fits ? trial[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
         num_in  = {num_ff[MAG_BITS-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
      end
   end

   // Control state is reset; the datapath words are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

`default_nettype wire

FILE: design/rmv_multiplier.sv
// Shift-and-add multiplier of two magnitudes, one multiplier bit per cycle.
`default_nettype none

module rmv_multiplier
   import rmv_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [MAG_BITS-1:0] op_a,
   input  wire logic [MAG_BITS-1:0] op_b,
   output logic                     done,
   output logic [PROD_BITS-1:0]     product
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [MAG_BITS-1:0]  a_ff, a_in;
   logic [PROD_BITS-1:0] acc_ff, acc_in;
   logic [MAG_BITS:0]    upper_sum;

   // The low half starts as the multiplier and is shifted out as the product
   // grows into it; a set low bit adds the multiplicand to the upper half.
   always_comb begin
      upper_sum = {1'b0, acc_ff[PROD_BITS-1:MAG_BITS]}
                + (acc_ff[0] ? {1'b0, a_ff} : {(MAG_BITS+1){1'b0}});
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      a_in      = a_ff;
      acc_in    = acc_ff;
      if (busy_ff) begin
         acc_in  = {upper_sum, acc_ff[MAG_BITS-1:1]};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         a_in    = op_a;
         acc_in  = {{MAG_BITS{1'b0}}, op_b};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

FILE: design/rmv_checker.sv
// Port-level checks of the running statistics block and their attachment to it.
`default_nettype none

module rmv_checker
   import rmv_pkg::*;
(
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [COUNT_BITS-1:0]         count_out,
   input wire logic signed [SAMPLE_BITS-1:0] min_out,
   input wire logic signed [SAMPLE_BITS-1:0] max_out,
   input wire logic signed [MEAN_BITS-1:0]   mean_out,
   input wire logic [M2_BITS-1:0]            m2_out,
   input wire logic                          saturated
);

   // A result word stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word withdrawn before it was taken");

   // A sample is worked on alone: the input closes right after an acceptance.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input still open in the cycle after an acceptance");

   // Every result follows at least one sample, so the extremes are ordered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (count_out != '0) && (min_out <= max_out))
      else $error("empty count or minimum above maximum");

   // After a single sample the mean equals it and nothing has accumulated.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (count_out == COUNT_ONE) |->
         (m2_out == '0) && !saturated && (min_out == max_out)
         && (mean_out == {min_out, {FRAC_BITS{1'b0}}}))
      else $error("first-sample result inconsistent");

endmodule

bind running_mean_variance_minmax rmv_checker u_rmv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .count_out (rsp_ch.count_out),
   .min_out   (rsp_ch.min_out),
   .max_out   (rsp_ch.max_out),
   .mean_out  (rsp_ch.mean_out),
   .m2_out    (rsp_ch.m2_out),
   .saturated (rsp_ch.saturated)
);

`default_nettype wire
